// File: sv/atl_pkg.sv
// Shared types, widths and constants for the accelerometer tilt-angle block.
// Used by every module of the block; depends on nothing.
package atl_pkg;

   localparam int SAMPLE_BITS  = 16;
   localparam int FILT_BITS    = SAMPLE_BITS + 8;
   localparam int WEIGHT_BITS  = 9;
   localparam int ANGLE_BITS   = 16;
   localparam int CORDIC_STEPS = 16;
   localparam int RAD_BITS     = 2 * FILT_BITS;
   localparam int ROOT_STEPS   = FILT_BITS;
   localparam int NORM_BIT     = 40;
   localparam int COARSE_BIT   = NORM_BIT - 4;
   localparam int CW           = NORM_BIT + 6;
   localparam int ZW           = 25;
   localparam int STEP_BITS    = 5;

   localparam logic [WEIGHT_BITS-1:0] WEIGHT_RESET = WEIGHT_BITS'(128);
   localparam logic [WEIGHT_BITS-1:0] WEIGHT_MAX   = WEIGHT_BITS'(256);
   localparam logic signed [ZW-1:0]   DEG90_Q16    = ZW'(90 * 65536);

   localparam logic [STEP_BITS-1:0] LAST_AXIS = STEP_BITS'(2);
   localparam logic [STEP_BITS-1:0] LAST_ROOT = STEP_BITS'(ROOT_STEPS - 1);
   localparam logic [STEP_BITS-1:0] LAST_ROT  = STEP_BITS'(CORDIC_STEPS - 1);

   localparam logic OP_ROLL  = 1'b0;
   localparam logic OP_PITCH = 1'b1;

   typedef enum logic [3:0] {
      S_IDLE, S_FILT, S_SQ1, S_SQ2, S_ROOT, S_LOAD, S_NORM, S_ROT, S_DONE
   } state_type;

   typedef struct packed {
      logic                 capture;
      logic                 filt;
      logic                 sq1;
      logic                 sq2;
      logic                 root;
      logic                 load;
      logic                 norm;
      logic                 rot;
      logic [STEP_BITS-1:0] step;
   } ctrl_type;

   typedef struct packed {
      logic norm_zero;
      logic norm_done;
   } status_type;

   function automatic logic signed [ZW-1:0] atan_q16(input logic [STEP_BITS-1:0] i);
      logic signed [ZW-1:0] v;
      case (i)
         5'd0:  v = ZW'(2949120);
         5'd1:  v = ZW'(1740967);
         5'd2:  v = ZW'(919879);
         5'd3:  v = ZW'(466945);
         5'd4:  v = ZW'(234379);
         5'd5:  v = ZW'(117304);
         5'd6:  v = ZW'(58666);
         5'd7:  v = ZW'(29335);
         5'd8:  v = ZW'(14668);
         5'd9:  v = ZW'(7334);
         5'd10: v = ZW'(3667);
         5'd11: v = ZW'(1833);
         5'd12: v = ZW'(917);
         5'd13: v = ZW'(458);
         5'd14: v = ZW'(229);
         5'd15: v = ZW'(115);
         5'd16: v = ZW'(57);
         5'd17: v = ZW'(29);
         5'd18: v = ZW'(14);
         5'd19: v = ZW'(7);
         5'd20: v = ZW'(4);
         5'd21: v = ZW'(2);
         5'd22: v = ZW'(1);
         default: v = '0;
      endcase
      return v;
   endfunction

endpackage

// File: sv/atl_ctrl.sv
// Sequencer for the tilt-angle block: walks filter, square, root, load, normalize
// and rotate phases, then an output phase. Depends on atl_pkg.
module atl_ctrl import atl_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_accept,
   input  logic       out_free,
   input  status_type status,
   output ctrl_type   ctrl,
   output logic       busy,
   output logic       emit
);

   state_type            state_ff, state_in;
   logic [STEP_BITS-1:0] cnt_ff, cnt_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         cnt_ff   <= '0;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      cnt_in   = cnt_ff;
      ctrl     = '0;
      ctrl.step = cnt_ff;
      busy     = (state_ff != S_IDLE);
      emit     = 1'b0;
      case (state_ff)
         S_IDLE: begin
            if (req_accept) begin
               ctrl.capture = 1'b1;
               state_in     = S_FILT;
               cnt_in       = '0;
            end
         end
         S_FILT: begin
            ctrl.filt = 1'b1;
            cnt_in    = cnt_ff + 1'b1;
            if (cnt_ff == LAST_AXIS) begin
               state_in = S_SQ1;
            end
         end
         S_SQ1: begin
            ctrl.sq1 = 1'b1;
            state_in = S_SQ2;
         end
         S_SQ2: begin
            ctrl.sq2 = 1'b1;
            state_in = S_ROOT;
            cnt_in   = '0;
         end
         S_ROOT: begin
            ctrl.root = 1'b1;
            cnt_in    = cnt_ff + 1'b1;
            if (cnt_ff == LAST_ROOT) begin
               state_in = S_LOAD;
            end
         end
         S_LOAD: begin
            ctrl.load = 1'b1;
            state_in  = S_NORM;
         end
         S_NORM: begin
            if (status.norm_zero) begin
               state_in = S_DONE;
            end else if (status.norm_done) begin
               state_in = S_ROT;
               cnt_in   = '0;
            end else begin
               ctrl.norm = 1'b1;
            end
         end
         S_ROT: begin
            ctrl.rot = 1'b1;
            cnt_in   = cnt_ff + 1'b1;
            if (cnt_ff == LAST_ROT) begin
               state_in = S_DONE;
            end
         end
         S_DONE: begin
            if (out_free) begin
               emit     = 1'b1;
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

endmodule

// File: sv/atl_dp.sv
// Datapath of the tilt-angle block: axis filters, sum of squares, bit-pair
// square root, normalizer and shared CORDIC stage. Depends on atl_pkg.
module atl_dp import atl_pkg::*; (
   input  logic                          clock,
   input  logic                          reset,
   input  ctrl_type                      ctrl,
   input  logic [WEIGHT_BITS-1:0]        weight,
   input  logic                          req_operation,
   input  logic signed [SAMPLE_BITS-1:0] req_accel_x,
   input  logic signed [SAMPLE_BITS-1:0] req_accel_y,
   input  logic signed [SAMPLE_BITS-1:0] req_accel_z,
   output status_type                    status,
   output logic signed [ANGLE_BITS-1:0]  angle_q8
);

   logic signed [FILT_BITS-1:0]   fx_ff, fy_ff, fz_ff;
   logic signed [SAMPLE_BITS-1:0] sx_ff, sy_ff, sz_ff;
   logic                          op_ff;
   logic [RAD_BITS-1:0]           sq_ff, rad_ff, res_ff, bit_ff;
   logic signed [CW-1:0]          x_ff, y_ff, x_in, y_in;
   logic signed [ZW-1:0]          z_ff, z_in;

   logic signed [FILT_BITS-1:0]   f_sel, new_f, num, p_sel, q_sel, sq_op;
   logic signed [SAMPLE_BITS-1:0] s_sel;
   logic signed [FILT_BITS+1:0]   diff;
   logic signed [FILT_BITS+11:0]  prod, acc;
   logic signed [RAD_BITS-1:0]    sq_prod;
   logic [RAD_BITS-1:0]           trial;
   logic                          fits;
   logic [CW-1:0]                 ay, mag_xy;
   logic signed [CW-1:0]          xs, ys;
   logic                          y_pos;
   logic signed [ZW-1:0]          zc, zmag, zsum, zr;
   logic [ZW-1:0]                 rsum;

   always_comb begin
      case (ctrl.step[1:0])
         2'd0:    begin f_sel = fx_ff; s_sel = sx_ff; end
         2'd1:    begin f_sel = fy_ff; s_sel = sy_ff; end
         default: begin f_sel = fz_ff; s_sel = sz_ff; end
      endcase
      diff  = {{2{s_sel[SAMPLE_BITS-1]}}, s_sel, 8'h00} - {{2{f_sel[FILT_BITS-1]}}, f_sel};
      prod  = $signed({1'b0, weight}) * diff;
      acc   = {{4{f_sel[FILT_BITS-1]}}, f_sel, 8'h00} + prod + (FILT_BITS+12)'(128);
      new_f = acc[FILT_BITS+7:8];

      if (op_ff == OP_ROLL) begin
         num = fy_ff; p_sel = fx_ff;
      end else begin
         num = fx_ff; p_sel = fy_ff;
      end
      q_sel   = fz_ff;
      sq_op   = ctrl.sq1 ? p_sel : q_sel;
      sq_prod = sq_op * sq_op;

      trial = res_ff + bit_ff;
      fits  = (rad_ff >= trial);

      ay     = y_ff[CW-1] ? CW'(-y_ff) : CW'(y_ff);
      mag_xy = (ay > CW'(x_ff)) ? ay : CW'(x_ff);
      status.norm_zero = (mag_xy == '0);
      status.norm_done = |mag_xy[CW-1:NORM_BIT];

      xs    = x_ff >>> ctrl.step;
      ys    = y_ff >>> ctrl.step;
      y_pos = !y_ff[CW-1] && (y_ff != '0);

      x_in = x_ff;
      y_in = y_ff;
      z_in = z_ff;
      if (ctrl.load) begin
         x_in = CW'($signed({1'b0, res_ff}));
         y_in = CW'(num);
         z_in = '0;
      end else if (ctrl.norm) begin
         if (mag_xy[CW-1:COARSE_BIT] == '0) begin
            x_in = x_ff <<< 4;
            y_in = y_ff <<< 4;
         end else begin
            x_in = x_ff <<< 1;
            y_in = y_ff <<< 1;
         end
      end else if (ctrl.rot) begin
         if (y_pos) begin
            x_in = x_ff + ys;
            y_in = y_ff - xs;
            z_in = z_ff + atan_q16(ctrl.step);
         end else begin
            x_in = x_ff - ys;
            y_in = y_ff + xs;
            z_in = z_ff - atan_q16(ctrl.step);
         end
      end

      if (z_ff > DEG90_Q16) begin
         zc = DEG90_Q16;
      end else if (z_ff < -DEG90_Q16) begin
         zc = -DEG90_Q16;
      end else begin
         zc = z_ff;
      end
      zmag = zc[ZW-1] ? -zc : zc;
      rsum = ZW'(zmag) + ZW'(32768);
      zsum = zc + ZW'(128);
      zr   = zsum >>> 8;
      if (op_ff == OP_ROLL) begin
         angle_q8 = zc[ZW-1] ? -$signed({rsum[23:16], 8'h00})
                             : $signed({rsum[23:16], 8'h00});
      end else begin
         angle_q8 = zr[ANGLE_BITS-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fx_ff <= '0;
         fy_ff <= '0;
         fz_ff <= '0;
      end else if (ctrl.filt) begin
         case (ctrl.step[1:0])
            2'd0:    fx_ff <= new_f;
            2'd1:    fy_ff <= new_f;
            default: fz_ff <= new_f;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (ctrl.capture) begin
         sx_ff <= req_accel_x;
         sy_ff <= req_accel_y;
         sz_ff <= req_accel_z;
         op_ff <= req_operation;
      end
      if (ctrl.sq1) begin
         sq_ff <= sq_prod;
      end
      if (ctrl.sq2) begin
         rad_ff <= sq_ff + sq_prod;
         res_ff <= '0;
         bit_ff <= RAD_BITS'(1) << (RAD_BITS - 2);
      end else if (ctrl.root) begin
         if (fits) begin
            rad_ff <= rad_ff - trial;
            res_ff <= (res_ff >> 1) + bit_ff;
         end else begin
            res_ff <= res_ff >> 1;
         end
         bit_ff <= bit_ff >> 2;
      end
      x_ff <= x_in;
      y_ff <= y_in;
      z_ff <= z_in;
   end

endmodule

// File: sv/accel_tilt_angle.sv
// Top level of the accelerometer tilt-angle block: handshake, weight register,
// result register. Depends on atl_pkg, atl_ctrl and atl_dp.
//
// Each request filters the three axes and returns roll or pitch in degrees Q8.
// A request passes through filter, square, square-root, load, normalize, CORDIC
// and output steps. An all-zero filtered vector skips the CORDIC and goes from
// normalize straight to output. The block returns to idle after the output step
// before it takes the next request, and the output step lasts longer while an
// earlier result is still stalled. The square root works one bit pair per cycle
// and the CORDIC is a single shared stage. req_stall is high while a request is
// in work; the result register lets a new request enter while an earlier result
// waits.
module accel_tilt_angle import atl_pkg::*; (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          csr_write,
   input  logic [WEIGHT_BITS-1:0]        csr_filter_weight,
   input  logic                          req_valid,
   output logic                          req_stall,
   input  logic                          req_operation,
   input  logic signed [SAMPLE_BITS-1:0] req_accel_x,
   input  logic signed [SAMPLE_BITS-1:0] req_accel_y,
   input  logic signed [SAMPLE_BITS-1:0] req_accel_z,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic signed [ANGLE_BITS-1:0]  rsp_angle_q8
);

   logic [WEIGHT_BITS-1:0]       weight_ff, weight_eff;
   logic                         rsp_valid_ff, rsp_valid_in;
   logic signed [ANGLE_BITS-1:0] angle_ff, angle;
   logic                         busy, emit, out_free, req_accept;
   ctrl_type                     ctrl;
   status_type                   status;

   assign out_free   = !rsp_valid_ff || !rsp_stall;
   assign req_stall  = busy;
   assign req_accept = req_valid && !busy;
   assign weight_eff = (weight_ff == '0) ? WEIGHT_BITS'(1) :
                       (weight_ff > WEIGHT_MAX) ? WEIGHT_MAX : weight_ff;
   assign rsp_valid_in = emit ? 1'b1 : (rsp_stall ? rsp_valid_ff : 1'b0);

   atl_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_accept (req_accept),
      .out_free   (out_free),
      .status     (status),
      .ctrl       (ctrl),
      .busy       (busy),
      .emit       (emit)
   );

   atl_dp u_dp (
      .clock         (clock),
      .reset         (reset),
      .ctrl          (ctrl),
      .weight        (weight_eff),
      .req_operation (req_operation),
      .req_accel_x   (req_accel_x),
      .req_accel_y   (req_accel_y),
      .req_accel_z   (req_accel_z),
      .status        (status),
      .angle_q8      (angle)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         weight_ff    <= WEIGHT_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_write) begin
            weight_ff <= csr_filter_weight;
         end
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (emit) begin
         angle_ff <= angle;
      end
   end

   assign rsp_valid    = rsp_valid_ff;
   assign rsp_angle_q8 = angle_ff;

endmodule

// File: sv/atl_checker.sv
// Port-level checks for the tilt-angle block, bound to the top level.
// Depends on atl_pkg and accel_tilt_angle.
module atl_checker import atl_pkg::*; (
   input logic                          clock,
   input logic                          reset,
   input logic                          req_valid,
   input logic                          req_stall,
   input logic                          req_operation,
   input logic signed [SAMPLE_BITS-1:0] req_accel_x,
   input logic signed [SAMPLE_BITS-1:0] req_accel_y,
   input logic signed [SAMPLE_BITS-1:0] req_accel_z,
   input logic                          rsp_valid,
   input logic                          rsp_stall,
   input logic signed [ANGLE_BITS-1:0]  rsp_angle_q8
);

   a_reset_idle: assert property (@(posedge clock) reset |=> !rsp_valid && !req_stall)
      else $error("block not idle after reset");

   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> req_stall)
      else $error("request taken without going busy");

   a_req_hold: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_stall |=> $stable(req_operation) && $stable(req_accel_x) &&
                                 $stable(req_accel_y) && $stable(req_accel_z))
      else $error("stalled request changed");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_angle_q8))
      else $error("stalled result changed");

   a_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_angle_q8 <= 16'sd23040 && rsp_angle_q8 >= -16'sd23040)
      else $error("angle out of range");

endmodule

bind accel_tilt_angle atl_checker u_atl_checker (.*);

// File: dv/testbench.sv
// Testbench for accel_tilt_angle: random and directed roll/pitch requests, checked
// against a bit-exact predictor of the filter, square root and CORDIC arctangent.
// Depends on atl_pkg and the accel_tilt_angle RTL.
`timescale 1ns / 1ps

class angle_scoreboard;
   logic [8:0] weight;
   longint filt_x, filt_y, filt_z;
   logic signed [15:0] pending[$];
   int errors;

   function new();
      weight = 9'd128;
      filt_x = 0;
      filt_y = 0;
      filt_z = 0;
      errors = 0;
   endfunction

   function longint shr_floor(longint v, int s);
      return v >>> s;
   endfunction

   function longint low_pass(longint f, longint s, longint w);
      longint acc;
      acc = (256 - w) * f + w * s * 256 + 128;
      acc = acc >>> 8;
      acc = acc & 64'hFF_FFFF;
      if (acc[23]) acc = acc - 64'h100_0000;
      return acc;
   endfunction

   function longint floor_root(longint unsigned v);
      longint unsigned res, bitv;
      res = 0;
      bitv = 64'd1 << 62;
      while (bitv > v) bitv = bitv >> 2;
      while (bitv != 0) begin
         if (v >= res + bitv) begin
            v = v - (res + bitv);
            res = (res >> 1) + bitv;
         end else begin
            res = res >> 1;
         end
         bitv = bitv >> 2;
      end
      return res;
   endfunction

   function longint tilt_deg_q16(longint num, longint p, longint q);
      longint x, y, z, m, xs, ys;
      longint up, uq;
      up = p < 0 ? -p : p;
      uq = q < 0 ? -q : q;
      x = floor_root(up * up + uq * uq);
      y = num;
      z = 0;
      m = y < 0 ? -y : y;
      if (x > m) m = x;
      if (m == 0) return 0;
      while (m < (64'sd1 << 40)) begin
         m = m * 2;
         x = x * 2;
         y = y * 2;
      end
      for (int i = 0; i < atl_pkg::CORDIC_STEPS; i++) begin
         xs = x >>> i;
         ys = y >>> i;
         if (y > 0) begin
            x = x + ys;
            y = y - xs;
            z = z + longint'(atl_pkg::atan_q16(5'(i)));
         end else begin
            x = x - ys;
            y = y + xs;
            z = z - longint'(atl_pkg::atan_q16(5'(i)));
         end
      end
      if (z > 90 * 65536) z = 90 * 65536;
      if (z < -90 * 65536) z = -90 * 65536;
      return z;
   endfunction

   function void note_request(logic op, logic signed [15:0] ax, logic signed [15:0] ay,
                              logic signed [15:0] az);
      longint w, z, mag, res;
      w = weight;
      if (w < 1) w = 1;
      if (w > 256) w = 256;
      filt_x = low_pass(filt_x, ax, w);
      filt_y = low_pass(filt_y, ay, w);
      filt_z = low_pass(filt_z, az, w);
      if (op == atl_pkg::OP_ROLL) begin
         z = tilt_deg_q16(filt_y, filt_x, filt_z);
         mag = z < 0 ? -z : z;
         mag = ((mag + 32768) >> 16) * 256;
         res = z < 0 ? -mag : mag;
      end else begin
         z = tilt_deg_q16(filt_x, filt_y, filt_z);
         res = (z + 128) >>> 8;
      end
      if (res > 23040) res = 23040;
      if (res < -23040) res = -23040;
      pending.push_back(16'(res));
   endfunction

   function void check_angle(logic signed [15:0] got);
      logic signed [15:0] want;
      if (pending.size() == 0) begin
         $display("%0t: unexpected angle, expected none, actual %0d", $time, got);
         errors++;
         return;
      end
      want = pending.pop_front();
      if (got !== want) begin
         $display("%0t: angle_q8 expected %0d actual %0d", $time, want, got);
         errors++;
      end
   endfunction
endclass

module testbench;
   import atl_pkg::*;

   logic clock, reset;
   logic csr_write;
   logic [WEIGHT_BITS-1:0] csr_filter_weight;
   logic req_valid, req_stall, req_operation;
   logic signed [SAMPLE_BITS-1:0] req_accel_x, req_accel_y, req_accel_z;
   logic rsp_valid, rsp_stall;
   logic signed [ANGLE_BITS-1:0] rsp_angle_q8;

   angle_scoreboard angles = new();
   bit quiet_tail, hold_long, feed_done;

   accel_tilt_angle dut (
      .clock, .reset, .csr_write, .csr_filter_weight,
      .req_valid, .req_stall, .req_operation, .req_accel_x, .req_accel_y, .req_accel_z,
      .rsp_valid, .rsp_stall, .rsp_angle_q8
   );

   initial begin
      clock = 0;
      forever #6 clock = ~clock;
   end

   initial begin
      #50ms;
      $display("Mismatches found");
      $finish;
   end

   task automatic set_weight(logic [WEIGHT_BITS-1:0] w);
      @(posedge clock);
      csr_write <= 1'b1;
      csr_filter_weight <= w;
      angles.weight = w;
      @(posedge clock);
      csr_write <= 1'b0;
   endtask

   task automatic send_request(logic op, logic signed [15:0] ax, logic signed [15:0] ay,
                               logic signed [15:0] az);
      if (!quiet_tail && $urandom_range(0, 3) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 17)) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_operation <= op;
      req_accel_x <= ax;
      req_accel_y <= ay;
      req_accel_z <= az;
      do @(posedge clock); while (req_stall);
      angles.note_request(op, ax, ay, az);
   endtask

   task automatic wait_drained();
      req_valid <= 1'b0;
      while (angles.pending.size() != 0) @(posedge clock);
      repeat (80) @(posedge clock);
   endtask

   function automatic logic signed [15:0] pick_sample();
      case ($urandom_range(0, 5))
         0: return 16'sh7FFF;
         1: return 16'sh8000;
         2: return 16'(signed'($urandom_range(0, 64)) - 32);
         default: return 16'($urandom);
      endcase
   endfunction

   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) angles.check_angle(rsp_angle_q8);
   end

   initial begin
      int quiet;
      rsp_stall = 1'b0;
      @(negedge reset);
      forever begin
         if (hold_long) begin
            rsp_stall <= 1'b1;
            repeat (400) @(posedge clock);
            hold_long = 0;
         end
         if (!quiet_tail && $urandom_range(0, 3) == 0) begin
            rsp_stall <= 1'b1;
            repeat ($urandom_range(1, 17)) @(posedge clock);
         end
         rsp_stall <= 1'b0;
         quiet = $urandom_range(1, 20);
         repeat (quiet) @(posedge clock);
      end
   end

   initial begin
      logic [8:0] weights[6];
      weights = '{9'd0, 9'd1, 9'd256, 9'd511, 9'd200, 9'd77};
      reset = 1'b1;
      csr_write = 1'b0;
      csr_filter_weight = '0;
      req_valid = 1'b0;
      req_operation = 1'b0;
      req_accel_x = '0;
      req_accel_y = '0;
      req_accel_z = '0;
      repeat (12) @(posedge clock);
      reset <= 1'b0;

      // zero vector under the reset weight, then extremes under weight 256
      send_request(OP_ROLL, 0, 0, 0);
      send_request(OP_PITCH, 0, 0, 0);
      wait_drained();
      set_weight(9'd256);
      send_request(OP_ROLL, 16'sh7FFF, 16'sh7FFF, 0);
      send_request(OP_PITCH, 16'sh8000, 16'sh7FFF, 16'sh7FFF);
      send_request(OP_ROLL, 0, 16'sh8000, 0);
      send_request(OP_PITCH, 16'sh7FFF, 0, 0);
      send_request(OP_PITCH, 16'sh8000, 0, 0);
      send_request(OP_ROLL, 0, 16'sh7FFF, 0);
      send_request(OP_ROLL, 16'sh8000, 16'sh8000, 16'sh8000);
      send_request(OP_PITCH, 16'sh7FFF, 16'sh7FFF, 16'sh7FFF);
      send_request(OP_ROLL, 1, -1, 1);
      send_request(OP_PITCH, -1, 1, -1);
      send_request(OP_ROLL, 100, 100, 0);
      send_request(OP_ROLL, 0, -100, 100);

      // fill the block while the result side holds off
      hold_long = 1;
      repeat (12) send_request(1'($urandom), pick_sample(), pick_sample(), pick_sample());
      wait_drained();

      foreach (weights[k]) begin
         set_weight(weights[k]);
         repeat (70) send_request(1'($urandom), pick_sample(), pick_sample(), pick_sample());
         wait_drained();
      end
      set_weight(9'($urandom_range(1, 256)));
      quiet_tail = 1;
      repeat (20) send_request(1'($urandom), pick_sample(), pick_sample(), pick_sample());
      wait_drained();

      if (angles.errors == 0 && angles.pending.size() == 0)
         $display("No mismatches found");
      else
         $display("Mismatches found");
      $finish;
   end
endmodule

// File: files.f
sv/atl_pkg.sv
sv/atl_ctrl.sv
sv/atl_dp.sv
sv/accel_tilt_angle.sv
sv/atl_checker.sv
dv/testbench.sv
